// File: hw/rtl/drl_pkg.sv
// ---------------------------------------------------------------------------
// drl_pkg: shared types and constants of the dense line rasteriser
// Controller states, command and status bundles, fixed widths.
// ---------------------------------------------------------------------------
package drl_pkg;

    // default coordinate format
    localparam int DEF_INT_BITS  = 5;
    localparam int DEF_FRAC_BITS = 8;

    // slope quotient fraction bits
    localparam int SLOPE_FRAC = 16;

    // cells per segment at most, and output cell field width
    localparam int MAX_CELLS = 64;
    localparam int CNT_W     = $clog2(MAX_CELLS + 1);
    localparam int CELL_W    = 5;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SETUP,
        ST_DIV,
        ST_CMUL,
        ST_CADD,
        ST_LOOP,
        ST_STEP,
        ST_FINAL
    } drl_state_t;

    // which cell goes to the output register
    typedef enum logic [1:0] {
        CSEL_WALK,
        CSEL_STEP,
        CSEL_END
    } cell_sel_t;

    typedef struct packed {
        logic      load_in;
        logic      setup;
        logic      div_start;
        logic      load_m;
        logic      mul;
        logic      cadd;
        logic      emit;
        cell_sel_t cell_sel;
        logic      adv_a;
        logic      step_b;
        logic      cross_off;
    } drl_cmd_t;

    typedef struct packed {
        logic straight;
        logic div_done;
        logic slot_free;
        logic a_done;
        logic b_done;
        logic b_step_done;
        logic match;
    } drl_status_t;

endpackage

// File: hw/rtl/drl_divider.sv
// ---------------------------------------------------------------------------
// drl_divider: iterative restoring divider
// Computes (num << SHIFT) / den on unsigned values, one quotient bit a cycle.
// ---------------------------------------------------------------------------
module drl_divider #(
    parameter int NUM_W = 13,
    parameter int SHIFT = 16
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [NUM_W-1:0]         num,
    input  logic [NUM_W-1:0]         den,
    output logic                     busy,
    output logic                     done,
    output logic [NUM_W+SHIFT-1:0]   quo
);

    localparam int QW   = NUM_W + SHIFT;
    localparam int CNTW = $clog2(QW + 1);

    logic [QW-1:0]    quo_reg;
    logic [NUM_W-1:0] rem_reg;
    logic [NUM_W-1:0] den_reg;
    logic [CNTW-1:0]  cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [NUM_W:0]   rem_sh;
    logic [NUM_W:0]   rem_sub;
    logic             ge;

    // one restoring step
    always_comb
    begin
        rem_sh  = {rem_reg, quo_reg[QW-1]};
        rem_sub = rem_sh - {1'b0, den_reg};
        ge      = (rem_sh >= {1'b0, den_reg});
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNTW'(QW);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNTW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= {num, {SHIFT{1'b0}}};
            rem_reg <= '0;
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[QW-2:0], ge};
            rem_reg <= ge ? rem_sub[NUM_W-1:0] : rem_sh[NUM_W-1:0];
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

// File: hw/rtl/drl_datapath.sv
// ---------------------------------------------------------------------------
// drl_datapath: segment registers, slope, crossing and output register
// Sorts endpoints, holds the walk counters, computes the crossing cell.
// ---------------------------------------------------------------------------
module drl_datapath #(
    parameter int COORD_INT_BITS  = drl_pkg::DEF_INT_BITS,
    parameter int COORD_FRAC_BITS = drl_pkg::DEF_FRAC_BITS
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  drl_pkg::drl_cmd_t     cmd,
    output drl_pkg::drl_status_t  status,
    input  logic [COORD_INT_BITS+COORD_FRAC_BITS-1:0] x_start,
    input  logic [COORD_INT_BITS+COORD_FRAC_BITS-1:0] y_start,
    input  logic [COORD_INT_BITS+COORD_FRAC_BITS-1:0] x_end,
    input  logic [COORD_INT_BITS+COORD_FRAC_BITS-1:0] y_end,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [drl_pkg::CELL_W-1:0] cell_col,
    output logic [drl_pkg::CELL_W-1:0] cell_row,
    output logic                  last_cell
);

    localparam int IW  = COORD_INT_BITS;
    localparam int FW  = COORD_FRAC_BITS;
    localparam int CW  = IW + FW;
    localparam int SF  = drl_pkg::SLOPE_FRAC;
    localparam int QW  = CW + SF;
    localparam int MW  = QW + 1;
    localparam int DW  = CW + 2;
    localparam int PW  = MW + DW;
    localparam int VW  = PW + 1;
    localparam int KW  = SF + FW;
    localparam int NW  = VW - KW;

    // captured segment
    logic [CW-1:0] xs_reg, ys_reg, xe_reg, ye_reg;

    // walk state
    logic [IW-1:0] ia_reg, ia_end_reg, ib_reg, ib_end_reg;
    logic          a_dec_reg, b_dec_reg, row_walk_reg, cross_en_reg;
    logic [CW-1:0] p0_reg, q0_reg;
    logic          den_neg_reg;
    logic signed [MW-1:0] m_reg;
    logic signed [PW-1:0] prod_reg;
    logic signed [NW-1:0] nxt_reg;
    logic [drl_pkg::CNT_W-1:0] cnt_reg;

    // output register
    logic                      out_valid_reg;
    logic [drl_pkg::CELL_W-1:0] col_reg, row_reg;
    logic                      last_reg;

    // setup decode
    logic          sw1, sw2, vert, horz, xmaj;
    logic [CW-1:0] xa, ya, xb, yb, xc, yc, xd, yd, dx, dy, dyc, dxc;
    logic [IW-1:0] ixa, iya, ixb, iyb, ixc, iyc, ixd, iyd;
    logic [IW-1:0] s_ia, s_ia_end, s_ib, s_ib_end;
    logic          s_a_dec, s_b_dec, s_row_walk, s_den_neg;
    logic [CW-1:0] s_p0, s_q0, s_num, s_den;

    always_comb
    begin
        sw1 = (xe_reg < xs_reg);
        xa  = sw1 ? xe_reg : xs_reg;
        ya  = sw1 ? ye_reg : ys_reg;
        xb  = sw1 ? xs_reg : xe_reg;
        yb  = sw1 ? ys_reg : ye_reg;
        ixa = xa[CW-1:FW];
        iya = ya[CW-1:FW];
        ixb = xb[CW-1:FW];
        iyb = yb[CW-1:FW];
        vert = (ixa == ixb);
        horz = (iya == iyb);
        dx   = xb - xa;
        dy   = (yb >= ya) ? (yb - ya) : (ya - yb);
        xmaj = (dx >= dy);
        // y-major walks upwards in rows
        sw2 = (yb < ya);
        xc  = sw2 ? xb : xa;
        yc  = sw2 ? yb : ya;
        xd  = sw2 ? xa : xb;
        yd  = sw2 ? ya : yb;
        ixc = xc[CW-1:FW];
        iyc = yc[CW-1:FW];
        ixd = xd[CW-1:FW];
        iyd = yd[CW-1:FW];
        dyc = yd - yc;
        dxc = (xd >= xc) ? (xd - xc) : (xc - xd);

        s_p0 = xa;
        s_q0 = ya;
        s_num = dx;
        s_den = dy;
        s_den_neg = sw2;
        if (vert)
        begin
            s_ia = iya;  s_ia_end = iyb;  s_a_dec = (iyb < iya);
            s_ib = ixa;  s_ib_end = ixb;  s_b_dec = 1'b0;
            s_row_walk = 1'b1;
        end
        else if (horz || xmaj)
        begin
            s_ia = ixa;  s_ia_end = ixb;  s_a_dec = 1'b0;
            s_ib = iya;  s_ib_end = iyb;  s_b_dec = (iyb < iya);
            s_row_walk = 1'b0;
        end
        else
        begin
            s_ia = iyc;  s_ia_end = iyd;  s_a_dec = 1'b0;
            s_ib = ixc;  s_ib_end = ixd;  s_b_dec = (xd < xc);
            s_row_walk = 1'b1;
            s_p0 = yc;
            s_q0 = xc;
            s_num = dyc;
            s_den = dxc;
            s_den_neg = (xd < xc);
        end
    end

    // slope divider
    logic          div_busy, div_done;
    logic [QW-1:0] div_quo;

    drl_divider #(
        .NUM_W (CW),
        .SHIFT (SF)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (s_num),
        .den   (s_den),
        .busy  (div_busy),
        .done  (div_done),
        .quo   (div_quo)
    );

    // crossing arithmetic
    logic [IW:0]          bnd;
    logic [CW:0]          bnd_raw;
    logic signed [DW-1:0] diff;
    logic signed [VW-1:0] v;
    logic signed [NW-1:0] nxt_val;
    logic [IW-1:0]        ia_step, ib_step;

    always_comb
    begin
        bnd     = {1'b0, ib_reg} + {{IW{1'b0}}, (ib_reg < ib_end_reg)};
        bnd_raw = {bnd, {FW{1'b0}}};
        diff    = $signed({1'b0, bnd_raw}) - $signed({2'b00, q0_reg});
        v       = $signed({{(VW-CW-SF){1'b0}}, p0_reg, {SF{1'b0}}})
                  + VW'(prod_reg);
        // quotient by 2^KW, rounded toward zero
        nxt_val = v[VW-1:KW] + NW'(v[VW-1] && (|v[KW-1:0]));
        ia_step = a_dec_reg ? (ia_reg - 1'b1) : (ia_reg + 1'b1);
        ib_step = b_dec_reg ? (ib_reg - 1'b1) : (ib_reg + 1'b1);
    end

    // walk registers
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            xs_reg <= x_start;
            ys_reg <= y_start;
            xe_reg <= x_end;
            ye_reg <= y_end;
        end
        if (cmd.setup)
        begin
            ia_reg       <= s_ia;
            ia_end_reg   <= s_ia_end;
            ib_reg       <= s_ib;
            ib_end_reg   <= s_ib_end;
            a_dec_reg    <= s_a_dec;
            b_dec_reg    <= s_b_dec;
            row_walk_reg <= s_row_walk;
            p0_reg       <= s_p0;
            q0_reg       <= s_q0;
            den_neg_reg  <= s_den_neg;
        end
        else
        begin
            if (cmd.adv_a)
                ia_reg <= ia_step;
            if (cmd.step_b)
                ib_reg <= ib_step;
        end
        if (cmd.load_m)
            m_reg <= den_neg_reg ? -$signed({1'b0, div_quo}) : $signed({1'b0, div_quo});
        if (cmd.mul)
            prod_reg <= m_reg * diff;
        if (cmd.cadd)
            nxt_reg <= nxt_val;
    end

    // control registers of the datapath
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cross_en_reg  <= 1'b0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.setup)
                cross_en_reg <= !(vert || horz);
            else if (cmd.cross_off)
                cross_en_reg <= 1'b0;

            if (cmd.setup)
                cnt_reg <= '0;
            else if (cmd.emit && (cnt_reg < drl_pkg::CNT_W'(drl_pkg::MAX_CELLS)))
                cnt_reg <= cnt_reg + 1'b1;

            if (cmd.emit && (cnt_reg < drl_pkg::CNT_W'(drl_pkg::MAX_CELLS)))
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // output payload
    logic [IW-1:0] cell_a, cell_b;

    always_comb
    begin
        case (cmd.cell_sel)
            drl_pkg::CSEL_STEP:
            begin
                cell_a = ia_reg;
                cell_b = ib_step;
            end
            drl_pkg::CSEL_END:
            begin
                cell_a = ia_end_reg;
                cell_b = ib_end_reg;
            end
            default:
            begin
                cell_a = ia_reg;
                cell_b = ib_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit && (cnt_reg < drl_pkg::CNT_W'(drl_pkg::MAX_CELLS)))
        begin
            col_reg  <= drl_pkg::CELL_W'(row_walk_reg ? cell_b : cell_a);
            row_reg  <= drl_pkg::CELL_W'(row_walk_reg ? cell_a : cell_b);
            last_reg <= (cmd.cell_sel == drl_pkg::CSEL_END);
        end
    end

    // status back to the controller
    always_comb
    begin
        status.straight    = vert || horz;
        status.div_done    = div_done;
        status.slot_free   = !out_valid_reg || out_ready;
        status.a_done      = (ia_reg == ia_end_reg);
        status.b_done      = (ib_reg == ib_end_reg);
        status.b_step_done = (ib_step == ib_end_reg);
        status.match       = cross_en_reg && (nxt_reg == $signed({{(NW-IW){1'b0}}, ia_reg}));
    end

    assign out_valid = out_valid_reg;
    assign cell_col  = col_reg;
    assign cell_row  = row_reg;
    assign last_cell = last_reg;

    // checks
    a_cnt_cap: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= drl_pkg::CNT_W'(drl_pkg::MAX_CELLS))
        else $error("cell count beyond cap");

    a_emit_slot: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> (!out_valid_reg || out_ready))
        else $error("cell emitted over a waiting result");

    a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |-> !div_busy)
        else $error("divider restarted while busy");

    a_mul_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.mul |-> !div_busy)
        else $error("crossing computed before slope is ready");

endmodule

// File: hw/rtl/drl_ctrl.sv
// ---------------------------------------------------------------------------
// drl_ctrl: sequencer of the dense line rasteriser
// Steps through setup, slope division, crossing updates and the cell walk.
// ---------------------------------------------------------------------------
module drl_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  drl_pkg::drl_status_t  status,
    output drl_pkg::drl_cmd_t     cmd
);

    drl_pkg::drl_state_t state_reg, state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= drl_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            drl_pkg::ST_IDLE:
                if (in_valid)
                    state_next = drl_pkg::ST_SETUP;
            drl_pkg::ST_SETUP:
                state_next = status.straight ? drl_pkg::ST_LOOP : drl_pkg::ST_DIV;
            drl_pkg::ST_DIV:
                if (status.div_done)
                    state_next = drl_pkg::ST_CMUL;
            drl_pkg::ST_CMUL:
                state_next = drl_pkg::ST_CADD;
            drl_pkg::ST_CADD:
                state_next = drl_pkg::ST_LOOP;
            drl_pkg::ST_LOOP:
                if (!status.a_done)
                begin
                    if (status.slot_free && status.match)
                        state_next = drl_pkg::ST_STEP;
                end
                else if (status.b_done || status.slot_free)
                    state_next = drl_pkg::ST_FINAL;
            drl_pkg::ST_STEP:
                if (status.slot_free)
                    state_next = status.b_step_done ? drl_pkg::ST_LOOP : drl_pkg::ST_CMUL;
            drl_pkg::ST_FINAL:
                if (status.slot_free)
                    state_next = drl_pkg::ST_IDLE;
            default:
                state_next = drl_pkg::ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        cmd          = '0;
        cmd.cell_sel = drl_pkg::CSEL_WALK;
        in_ready     = 1'b0;
        unique case (state_reg)
            drl_pkg::ST_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.load_in = in_valid;
            end
            drl_pkg::ST_SETUP:
            begin
                cmd.setup     = 1'b1;
                cmd.div_start = !status.straight;
            end
            drl_pkg::ST_DIV:
                cmd.load_m = status.div_done;
            drl_pkg::ST_CMUL:
                cmd.mul = 1'b1;
            drl_pkg::ST_CADD:
                cmd.cadd = 1'b1;
            drl_pkg::ST_LOOP:
                if (!status.a_done)
                begin
                    cmd.emit  = status.slot_free;
                    cmd.adv_a = status.slot_free && !status.match;
                end
                else
                    cmd.emit = status.slot_free && !status.b_done;
            drl_pkg::ST_STEP:
            begin
                cmd.cell_sel  = drl_pkg::CSEL_STEP;
                cmd.emit      = status.slot_free;
                cmd.step_b    = status.slot_free;
                cmd.adv_a     = status.slot_free;
                cmd.cross_off = status.slot_free && status.b_step_done;
            end
            drl_pkg::ST_FINAL:
            begin
                cmd.cell_sel = drl_pkg::CSEL_END;
                cmd.emit     = status.slot_free;
            end
            default:
                cmd = '0;
        endcase
    end

    // checks
    a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == drl_pkg::ST_SETUP))
        else $error("accepted segment did not start setup");

    a_step_emits: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.step_b) |-> (cmd.emit && cmd.adv_a))
        else $error("row or column change without corner cell");

endmodule

// File: hw/rtl/dense_line_rasterizer.sv
// ---------------------------------------------------------------------------
// dense_line_rasterizer: 4-connected cell chain of a line segment
// Emits every grid cell touched by a fixed-point segment, corners included.
//
//   channel   dir  handshake          payload
//   s_*       in   tvalid/tready      tdata: x_start, y_start, x_end, y_end
//   m_*       out  tvalid/tready      tdata: cell_col, cell_row; tlast: last_cell
//
// One segment at a time. Diagonal segments go through transfer and setup,
// then wait on the slope divider and the first crossing multiply-add, then
// emit one cell per cycle while the output is not stalled, with a corner cell
// and a new crossing multiply-add at each row or column change, plus the end
// cell; straight segments skip the divider. Reset clears the sequencer and
// the output valid. A stalled output holds the walk; a new segment is taken
// once the final cell is in the output register.
// ---------------------------------------------------------------------------
module dense_line_rasterizer #(
    parameter int COORD_INT_BITS  = drl_pkg::DEF_INT_BITS,
    parameter int COORD_FRAC_BITS = drl_pkg::DEF_FRAC_BITS,
    localparam int CW  = COORD_INT_BITS + COORD_FRAC_BITS,
    localparam int SDW = ((4 * CW + 7) / 8) * 8
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           s_tvalid,
    output logic           s_tready,
    // x_start, y_start, x_end, y_end from bit 0 up, zero padded
    input  logic [SDW-1:0] s_tdata,
    output logic           m_tvalid,
    input  logic           m_tready,
    // cell_col, cell_row from bit 0 up, zero padded
    output logic [15:0]    m_tdata,
    output logic           m_tlast
);

    drl_pkg::drl_cmd_t    cmd;
    drl_pkg::drl_status_t status;
    logic [drl_pkg::CELL_W-1:0] col, row;

    drl_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    drl_datapath #(
        .COORD_INT_BITS  (COORD_INT_BITS),
        .COORD_FRAC_BITS (COORD_FRAC_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .x_start   (s_tdata[CW-1:0]),
        .y_start   (s_tdata[2*CW-1:CW]),
        .x_end     (s_tdata[3*CW-1:2*CW]),
        .y_end     (s_tdata[4*CW-1:3*CW]),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .cell_col  (col),
        .cell_row  (row),
        .last_cell (m_tlast)
    );

    assign m_tdata = {{(16 - 2 * drl_pkg::CELL_W){1'b0}}, row, col};

endmodule

// File: sim/tb_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top: self-checking bench for the dense line rasteriser
// Drives segments on the input stream and checks every emitted cell chain
// against an in-bench predictor of the 4-connected walk, with random idling
// on both streams and one long output hold-off to fill the block.
// ---------------------------------------------------------------------------
module tb_top;

    localparam int CW  = drl_pkg::DEF_INT_BITS + drl_pkg::DEF_FRAC_BITS;
    localparam int FB  = drl_pkg::DEF_FRAC_BITS;
    localparam int SDW = ((4 * CW + 7) / 8) * 8;
    localparam int N_DIRECTED = 16;

    typedef struct packed {
        logic [drl_pkg::CELL_W-1:0] col;
        logic [drl_pkg::CELL_W-1:0] row;
        logic                       last;
    } cell_t;

    typedef struct packed {
        logic [CW-1:0] xs;
        logic [CW-1:0] ys;
        logic [CW-1:0] xe;
        logic [CW-1:0] ye;
    } seg_t;

    logic           clk;
    logic           rst_n;
    logic           s_tvalid;
    logic           s_tready;
    logic [SDW-1:0] s_tdata;
    logic           m_tvalid;
    logic           m_tready;
    logic [15:0]    m_tdata;
    logic           m_tlast;

    cell_t cell_q[$];
    int    n_err;
    int    n_seg;
    int    n_cells;
    int    send_idle;
    int    recv_stall;
    int    hold_off;

    dense_line_rasterizer u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // clock, 10 ns period
    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // run limit
    initial
    begin
        #20ms;
        $display("FAIL");
        $finish;
    end

    task automatic report_err(input string msg);
        n_err++;
        $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    // slope quotient, truncated toward zero
    function automatic longint slope_div(input longint num, input longint den);
        if (den == 0)
            return 0;
        return (num * (64'sd1 <<< drl_pkg::SLOPE_FRAC)) / den;
    endfunction

    // cell index at which the segment crosses boundary bnd
    function automatic longint crossing(input longint p0, input longint q0,
                                        input longint m, input longint bnd);
        longint v;
        v = p0 * (64'sd1 <<< drl_pkg::SLOPE_FRAC) + m * (bnd - q0);
        return v / (64'sd1 <<< (drl_pkg::SLOPE_FRAC + FB));
    endfunction

    task automatic push_cell(ref cell_t q[$], input longint c, input longint r,
                             input bit last);
        cell_t e;
        if (q.size() >= drl_pkg::MAX_CELLS)
            return;
        e.col  = c[drl_pkg::CELL_W-1:0];
        e.row  = r[drl_pkg::CELL_W-1:0];
        e.last = last;
        q.push_back(e);
    endtask

    // work out the full cell chain of one segment
    task automatic predict_chain(input seg_t s, ref cell_t q[$]);
        longint x1, y1, x2, y2, t, ix1, ix2, iy1, iy2, dx, dy, inc, m, bnd, nxt;
        x1 = s.xs; y1 = s.ys; x2 = s.xe; y2 = s.ye;
        if (x2 < x1)
        begin
            t = x1; x1 = x2; x2 = t;
            t = y1; y1 = y2; y2 = t;
        end
        ix1 = x1 >>> FB; ix2 = x2 >>> FB;
        iy1 = y1 >>> FB; iy2 = y2 >>> FB;
        inc = (iy2 < iy1) ? -1 : 1;
        dx  = x2 - x1;
        dy  = (y2 >= y1) ? y2 - y1 : y1 - y2;
        if (ix1 == ix2)
        begin
            while (iy1 != iy2)
            begin
                push_cell(q, ix1, iy1, 0);
                iy1 += inc;
            end
        end
        else if (iy1 == iy2)
        begin
            while (ix1 != ix2)
            begin
                push_cell(q, ix1, iy1, 0);
                ix1 += 1;
            end
        end
        else if (dx >= dy)
        begin
            // x-major: walk columns, step rows at crossings
            m   = slope_div(x2 - x1, y2 - y1);
            bnd = iy1 + ((iy1 < iy2) ? 1 : 0);
            nxt = crossing(x1, y1, m, bnd <<< FB);
            while (ix1 != ix2)
            begin
                push_cell(q, ix1, iy1, 0);
                if (ix1 == nxt)
                begin
                    iy1 += inc;
                    push_cell(q, ix1, iy1, 0);
                    if (iy1 != iy2)
                    begin
                        bnd = iy1 + ((iy1 < iy2) ? 1 : 0);
                        nxt = crossing(x1, y1, m, bnd <<< FB);
                    end
                    else
                        nxt = ix2;
                end
                ix1 += 1;
            end
            if (iy1 != iy2)
                push_cell(q, ix1, iy1, 0);
        end
        else
        begin
            // y-major: reorder so rows rise, walk rows
            if (y2 < y1)
            begin
                t = x1; x1 = x2; x2 = t;
                t = y1; y1 = y2; y2 = t;
                ix1 = x1 >>> FB; ix2 = x2 >>> FB;
                iy1 = y1 >>> FB; iy2 = y2 >>> FB;
            end
            inc = (x2 < x1) ? -1 : 1;
            m   = slope_div(y2 - y1, x2 - x1);
            bnd = ix1 + ((ix1 < ix2) ? 1 : 0);
            nxt = crossing(y1, x1, m, bnd <<< FB);
            while (iy1 != iy2)
            begin
                push_cell(q, ix1, iy1, 0);
                if (iy1 == nxt)
                begin
                    ix1 += inc;
                    push_cell(q, ix1, iy1, 0);
                    if (ix1 != ix2)
                    begin
                        bnd = ix1 + ((ix1 < ix2) ? 1 : 0);
                        nxt = crossing(y1, x1, m, bnd <<< FB);
                    end
                    else
                        nxt = iy2;
                end
                iy1 += 1;
            end
            if (ix1 != ix2)
                push_cell(q, ix1, iy1, 0);
        end
        push_cell(q, ix2, iy2, 1);
    endtask

    // one segment transfer; valid stays high between back-to-back items
    task automatic send_seg(input seg_t s);
        seg_t sw;
        cell_t chain[$];
        sw = '{xs: s.xs, ys: s.ys, xe: s.xe, ye: s.ye};
        while ($urandom_range(99) < send_idle)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(SDW - 4 * CW){1'b0}}, sw.ye, sw.xe, sw.ys, sw.xs};
        do
            @(posedge clk);
        while (!s_tready);
        predict_chain(s, chain);
        foreach (chain[i])
            cell_q.push_back(chain[i]);
        n_seg++;
        @(negedge clk);
    endtask

    // random segment: mostly short, some long, some sharing a column or row
    function automatic seg_t rand_seg();
        seg_t s;
        int   k;
        k = $urandom_range(9);
        s.xs = CW'($urandom); s.ys = CW'($urandom);
        if (k < 6)
        begin
            s.xe = CW'(s.xs + $urandom_range(0, 2047) - 1024);
            s.ye = CW'(s.ys + $urandom_range(0, 2047) - 1024);
        end
        else if (k == 6)
        begin
            s.xe = {s.xs[CW-1:FB], FB'($urandom)};
            s.ye = CW'($urandom);
        end
        else if (k == 7)
        begin
            s.xe = CW'($urandom);
            s.ye = {s.ys[CW-1:FB], FB'($urandom)};
        end
        else
        begin
            s.xe = CW'($urandom); s.ye = CW'($urandom);
        end
        return s;
    endfunction

    // directed segments; a typed chain is given where it is obvious
    seg_t dir_seg[N_DIRECTED];
    bit   dir_known[N_DIRECTED];
    cell_t dir_cell[N_DIRECTED];

    initial
    begin
        dir_seg[0]  = '{13'h0000, 13'h0000, 13'h0000, 13'h0000}; // single cell
        dir_seg[1]  = '{13'h1FFF, 13'h1FFF, 13'h1FFF, 13'h1FFF}; // top corner
        dir_seg[2]  = '{13'h0080, 13'h0010, 13'h00FF, 13'h00F0}; // same cell
        dir_seg[3]  = '{13'h0000, 13'h0000, 13'h0000, 13'h1FFF}; // vertical up
        dir_seg[4]  = '{13'h1F00, 13'h1FFF, 13'h1FFF, 13'h0000}; // vertical down
        dir_seg[5]  = '{13'h0000, 13'h0000, 13'h1FFF, 13'h00FF}; // horizontal
        dir_seg[6]  = '{13'h1FFF, 13'h1F00, 13'h0000, 13'h1FFF}; // swapped horiz.
        dir_seg[7]  = '{13'h0000, 13'h0000, 13'h1FFF, 13'h1FFF}; // full diagonal
        dir_seg[8]  = '{13'h1FFF, 13'h0000, 13'h0000, 13'h1FFF}; // anti diagonal
        dir_seg[9]  = '{13'h0000, 13'h0000, 13'h1FFF, 13'h0300}; // x-major rising
        dir_seg[10] = '{13'h0080, 13'h1F80, 13'h1E80, 13'h1A00}; // x-major falling
        dir_seg[11] = '{13'h0100, 13'h0000, 13'h0400, 13'h1FFF}; // y-major
        dir_seg[12] = '{13'h0400, 13'h1FFF, 13'h0100, 13'h0000}; // y-major swap
        dir_seg[13] = '{13'h0A00, 13'h0000, 13'h0700, 13'h1FFF}; // y-major leftward
        dir_seg[14] = '{13'h01FF, 13'h01FF, 13'h0200, 13'h0200}; // corner touch
        dir_seg[15] = '{13'h1555, 13'h0AAA, 13'h0AAA, 13'h1555}; // bit patterns
        dir_known   = '{default: 1'b0};
        dir_known[0] = 1'b1; dir_cell[0] = '{5'd0, 5'd0, 1'b1};
        dir_known[1] = 1'b1; dir_cell[1] = '{5'd31, 5'd31, 1'b1};
        dir_known[2] = 1'b1; dir_cell[2] = '{5'd0, 5'd0, 1'b1};
    end

    // output side: stall, hold-off and checking
    initial
    begin
        m_tready = 1'b0;
        hold_off = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_off > 0)
            begin
                hold_off--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= ($urandom_range(99) >= recv_stall);
        end
    end

    always @(posedge clk)
    begin
        cell_t got, want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = '{m_tdata[drl_pkg::CELL_W-1:0],
                    m_tdata[2*drl_pkg::CELL_W-1:drl_pkg::CELL_W], m_tlast};
            n_cells++;
            if (cell_q.size() == 0)
                report_err($sformatf("unexpected cell %0d,%0d", got.col, got.row));
            else
            begin
                want = cell_q.pop_front();
                if (got.col !== want.col)
                    report_err($sformatf("col %0d, want %0d", got.col, want.col));
                if (got.row !== want.row)
                    report_err($sformatf("row %0d, want %0d", got.row, want.row));
                if (got.last !== want.last)
                    report_err($sformatf("last %0b, want %0b", got.last, want.last));
            end
            if (m_tdata[15:2*drl_pkg::CELL_W] !== '0)
                report_err("padding bits of output data not zero");
        end
    end

    // stimulus
    initial
    begin
        cell_t chain[$];
        int    waited;
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        n_err     = 0;
        n_seg     = 0;
        n_cells   = 0;
        send_idle = 0;
        recv_stall = 0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed rows, cross-checked against the predictor where typed in
        for (int i = 0; i < N_DIRECTED; i++)
        begin
            if (dir_known[i])
            begin
                chain.delete();
                predict_chain(dir_seg[i], chain);
                if (chain.size() != 1 || chain[0] != dir_cell[i])
                    report_err($sformatf("directed row %0d: predictor disagrees", i));
            end
            send_seg(dir_seg[i]);
        end

        // random phases with different idling
        for (int ph = 0; ph < 5; ph++)
        begin
            case (ph)
                0: begin send_idle = 0;  recv_stall = 0;  end
                1: begin send_idle = 61; recv_stall = 0;  end
                2: begin send_idle = 0;  recv_stall = 61; end
                3: begin send_idle = 18; recv_stall = 18; end
                default: begin send_idle = 0; recv_stall = 0; end
            endcase
            // long output hold-off while segments keep coming
            if (ph == 4)
                hold_off = 400;
            for (int k = 0; k < 32; k++)
                send_seg(rand_seg());
        end
        s_tvalid <= 1'b0;

        waited = 0;
        while (cell_q.size() != 0 && waited < 200000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (100) @(posedge clk);
        $display("Covered %0d segments (straight, x-major, y-major, swapped, extremes)",
                 n_seg);
        $display("and checked %0d emitted cells under several idling mixes.", n_cells);
        if (n_err == 0 && cell_q.size() == 0)
            $display("PASS");
        else
        begin
            if (cell_q.size() != 0)
                $display("%0d expected cells never arrived", cell_q.size());
            $display("FAIL");
        end
        $finish;
    end
endmodule
